// ===== sv/qsel_pkg.sv =====
`timescale 1ns / 1ps

package qsel_pkg;

  localparam int unsigned MAX_ELEMENTS = 1024;
  localparam int unsigned ADDR_W       = $clog2(MAX_ELEMENTS);
  localparam int unsigned CNT_W        = ADDR_W + 1;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned RANK_W       = 10;
  localparam int unsigned ERR_W        = 2;

  localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_RANK     = 2'd1;
  localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd2;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [DATA_W-1:0] data_t;

  // one write port of the value store
  typedef struct packed {
    logic  en;
    addr_t addr;
    data_t data;
  } qsel_wr_t;

endpackage

// ===== sv/quickselect_kth_smallest.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Words
// -------   ---------  ------------------------  -----------------------------
// item      in         start_i & !busy_o         value_i, last_item_i, rank_i
// result    out        result_valid_o (1 cycle)  selected_o, error_o
//
// Loading takes one cycle per word. A last word with an error gives its result
// in the next cycle. Otherwise selection runs while busy_o is high: each
// partition pass reads the pivot, scans the range and exchanges words through
// the single read and single write port of the value store, then places the
// pivot; a final range of one element is read out. Reset clears all control
// state; the store is not cleared. The receiver cannot stall the result strobe.

module quickselect_kth_smallest import qsel_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic                     last_item_i,
  input  logic        [RANK_W-1:0] rank_i,
  output logic                     result_valid_o,
  output logic signed [DATA_W-1:0] selected_o,
  output logic         [ERR_W-1:0] error_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_PIVOT = 4'd2;
  localparam logic [3:0] S_CMP   = 4'd3;
  localparam logic [3:0] S_SWAP  = 4'd4;
  localparam logic [3:0] S_SWAP2 = 4'd5;
  localparam logic [3:0] S_FIXRD = 4'd6;
  localparam logic [3:0] S_FIX   = 4'd7;
  localparam logic [3:0] S_FIX2  = 4'd8;
  localparam logic [3:0] S_LAST  = 4'd9;

  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             ovf_q, ovf_d;
  addr_t            lo_q, lo_d;
  addr_t            hi_q, hi_d;
  addr_t            k_q, k_d;
  addr_t            mark_q, mark_d;
  addr_t            scan_q, scan_d;
  data_t            pivot_q, pivot_d;
  data_t            hold_q, hold_d;

  logic             res_valid_q, res_valid_d;
  data_t            res_sel_q, res_sel_d;
  logic [ERR_W-1:0] res_err_q, res_err_d;

  qsel_wr_t         wr;
  addr_t            rd_addr;
  data_t            rd_data;

  logic             accept;
  logic [CNT_W-1:0] count_new;
  logic             ovf_new;
  addr_t            mark_inc;
  addr_t            offset;
  logic             le_pivot;

  qsel_store u_store (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign accept   = start_i && (state_q == S_IDLE);
  assign mark_inc = mark_q + addr_t'(1);
  assign offset   = mark_q - lo_q;
  // the one shared compare: scanned word against the pivot
  assign le_pivot = $signed(rd_data) <= $signed(pivot_q);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    k_d         = k_q;
    mark_d      = mark_q;
    scan_d      = scan_q;
    pivot_d     = pivot_q;
    hold_d      = hold_q;
    res_valid_d = 1'b0;
    res_sel_d   = res_sel_q;
    res_err_d   = res_err_q;
    wr          = '{en: 1'b0, addr: addr_t'(0), data: data_t'(0)};
    rd_addr     = lo_q;
    count_new   = count_q;
    ovf_new     = ovf_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (count_q < CNT_W'(MAX_ELEMENTS)) begin
            wr        = '{en: 1'b1, addr: count_q[ADDR_W-1:0], data: value_i};
            count_new = count_q + CNT_W'(1);
          end else begin
            ovf_new = 1'b1;
          end
          count_d = count_new;
          ovf_d   = ovf_new;
          if (last_item_i) begin
            count_d = '0;
            ovf_d   = 1'b0;
            if (ovf_new) begin
              res_valid_d = 1'b1;
              res_sel_d   = '0;
              res_err_d   = ERR_OVERFLOW;
            end else if (CNT_W'(rank_i) >= count_new) begin
              res_valid_d = 1'b1;
              res_sel_d   = '0;
              res_err_d   = ERR_RANK;
            end else begin
              lo_d    = '0;
              hi_d    = ADDR_W'(count_new - CNT_W'(1));
              k_d     = ADDR_W'(rank_i);
              state_d = S_CHECK;
            end
          end
        end
      end

      S_CHECK: begin
        rd_addr = lo_q;
        state_d = (lo_q >= hi_q) ? S_LAST : S_PIVOT;
      end

      S_PIVOT: begin
        pivot_d = rd_data;
        mark_d  = lo_q;
        scan_d  = lo_q + addr_t'(1);
        rd_addr = lo_q + addr_t'(1);
        state_d = S_CMP;
      end

      S_CMP: begin
        if (le_pivot && (mark_inc != scan_q)) begin
          // fetch the word at the new mark for the exchange
          hold_d  = rd_data;
          mark_d  = mark_inc;
          rd_addr = mark_inc;
          state_d = S_SWAP;
        end else begin
          if (le_pivot) begin
            mark_d = mark_inc;
          end
          if (scan_q == hi_q) begin
            state_d = S_FIXRD;
          end else begin
            scan_d  = scan_q + addr_t'(1);
            rd_addr = scan_q + addr_t'(1);
          end
        end
      end

      S_SWAP: begin
        wr      = '{en: 1'b1, addr: scan_q, data: rd_data};
        state_d = S_SWAP2;
      end

      S_SWAP2: begin
        wr = '{en: 1'b1, addr: mark_q, data: hold_q};
        if (scan_q == hi_q) begin
          state_d = S_FIXRD;
        end else begin
          scan_d  = scan_q + addr_t'(1);
          rd_addr = scan_q + addr_t'(1);
          state_d = S_CMP;
        end
      end

      S_FIXRD: begin
        rd_addr = mark_q;
        state_d = S_FIX;
      end

      S_FIX: begin
        wr      = '{en: 1'b1, addr: lo_q, data: rd_data};
        state_d = S_FIX2;
      end

      S_FIX2: begin
        // the pivot lands at the mark; report it if it holds the rank, else narrow to the side that holds the rank
        wr = '{en: 1'b1, addr: mark_q, data: pivot_q};
        if (offset == k_q) begin
          res_valid_d = 1'b1;
          res_sel_d   = pivot_q;
          res_err_d   = ERR_NONE;
          state_d     = S_IDLE;
        end else if (offset < k_q) begin
          k_d     = k_q - offset - addr_t'(1);
          lo_d    = mark_inc;
          state_d = S_CHECK;
        end else begin
          hi_d    = mark_q - addr_t'(1);
          state_d = S_CHECK;
        end
      end

      S_LAST: begin
        res_valid_d = 1'b1;
        res_sel_d   = rd_data;
        res_err_d   = ERR_NONE;
        state_d     = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      lo_q        <= '0;
      hi_q        <= '0;
      k_q         <= '0;
      mark_q      <= '0;
      scan_q      <= '0;
      pivot_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      k_q         <= k_d;
      mark_q      <= mark_d;
      scan_q      <= scan_d;
      pivot_q     <= pivot_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q    <= hold_d;
    res_sel_q <= res_sel_d;
    res_err_q <= res_err_d;
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = res_valid_q;
  assign selected_o     = res_sel_q;
  assign error_o        = res_err_q;

endmodule

// ===== sv/qsel_store.sv =====
`timescale 1ns / 1ps

module qsel_store import qsel_pkg::*; (
  input  logic     clk_i,
  input  qsel_wr_t wr_i,
  input  addr_t    rd_addr_i,
  output data_t    rd_data_o
);

  data_t mem [MAX_ELEMENTS];
  data_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  // read returns the old word when the same address is written
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== sv/qsel_checker.sv =====
`timescale 1ns / 1ps

module qsel_checker import qsel_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     start_i,
  input logic                     busy_o,
  input logic                     last_item_i,
  input logic                     result_valid_o,
  input logic signed [DATA_W-1:0] selected_o,
  input logic         [ERR_W-1:0] error_o
);

  // an error word carries a zero value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (error_o != ERR_NONE) |-> selected_o == '0)
    else $error("error word with nonzero value");

  // a word that is not last never produces a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && !last_item_i |=> !result_valid_o)
    else $error("result after a non-last word");

  // a last word either starts selection or reports at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && last_item_i |=> busy_o || result_valid_o)
    else $error("last word left no trace");

  // selection ends only with its result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> result_valid_o && (error_o == ERR_NONE))
    else $error("selection ended without a result");

  // no result while still selecting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !result_valid_o)
    else $error("result while busy");

endmodule

bind quickselect_kth_smallest qsel_checker u_qsel_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .last_item_i    (last_item_i),
  .result_valid_o (result_valid_o),
  .selected_o     (selected_o),
  .error_o        (error_o)
);
